### src/thfc_pkg.sv
// ----------------------------------------------------------------------------
// thfc_pkg
// Shared widths, codes and constants of the thermal hysteresis fan controller.
// ----------------------------------------------------------------------------
package thfc_pkg;

  localparam int TEMP_W       = 13;
  localparam int HYST_W       = 10;
  localparam int WINDOW_DEPTH = 8;
  localparam int WIN_AW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W        = TEMP_W + WIN_AW;
  localparam int THR_W        = TEMP_W + 2;

  localparam int TEMP_OFFSET      = 4096;
  localparam int AVG_BIAS         = WINDOW_DEPTH * TEMP_OFFSET;
  localparam int DUTY_LOW         = 77;
  localparam int DUTY_HIGH        = 255;
  localparam int DUTY_SPAN        = DUTY_HIGH - DUTY_LOW;
  localparam int CRIT_HYST_FACTOR = 2;

  localparam int DUTY_W     = 8;
  localparam int REM_W      = TEMP_W;
  localparam int PROD_W     = TEMP_W + DUTY_W;
  localparam int RAMP_STEPS = DUTY_W;
  localparam int CNT_W      = $clog2(RAMP_STEPS + 1);

  localparam logic [1:0] MODE_IDLE       = 2'd0;
  localparam logic [1:0] MODE_ACTIVE     = 2'd1;
  localparam logic [1:0] MODE_THROTTLING = 2'd2;
  localparam logic [1:0] MODE_CRITICAL   = 2'd3;

  localparam logic [1:0] PWR_NORMAL    = 2'd0;
  localparam logic [1:0] PWR_THROTTLED = 2'd1;
  localparam logic [1:0] PWR_CRITICAL  = 2'd2;

  localparam logic [1:0] REG_IDLE_LIMIT     = 2'd0;
  localparam logic [1:0] REG_ACTIVE_LIMIT   = 2'd1;
  localparam logic [1:0] REG_THROTTLE_LIMIT = 2'd2;
  localparam logic [1:0] REG_HYSTERESIS     = 2'd3;

  localparam logic signed [TEMP_W-1:0] IDLE_LIMIT_RST     = 13'sd640;
  localparam logic signed [TEMP_W-1:0] ACTIVE_LIMIT_RST   = 13'sd1120;
  localparam logic signed [TEMP_W-1:0] THROTTLE_LIMIT_RST = 13'sd1360;
  localparam logic [HYST_W-1:0]        HYSTERESIS_RST     = 10'd48;

  typedef logic [2:0] seq_state_t;

endpackage

### src/thermal_hysteresis_fan_controller_top.sv
// ----------------------------------------------------------------------------
// thermal_hysteresis_fan_controller_top
// Moving-average filter over a sample window in RAM, four-mode thermal state
// machine with hysteresis and a linear fan ramp through a bit-serial divider.
// ----------------------------------------------------------------------------
// path: sample transfer, window fill or update, average, mode decision, result; when
//   the fan ramp needs the divider, a setup state and 8 restoring steps come first
// sample_stall is high outside idle: a new sample waits until the last result is out
// the first sample after reset also writes every window entry
// reset: synchronous; mode idle, window empty, registers to their defaults
module thermal_hysteresis_fan_controller_top
  import thfc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic signed [TEMP_W-1:0] temperature,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [TEMP_W-1:0] filtered_temp,
  output logic [1:0]               thermal_mode,
  output logic [DUTY_W-1:0]        fan_duty,
  output logic [1:0]               power_state
);

  localparam seq_state_t S_IDLE   = 3'd0;
  localparam seq_state_t S_FILL   = 3'd1;
  localparam seq_state_t S_UPDATE = 3'd2;
  localparam seq_state_t S_AVG    = 3'd3;
  localparam seq_state_t S_DIV    = 3'd4;
  localparam seq_state_t S_MODE   = 3'd5;
  localparam seq_state_t S_MUL    = 3'd6;
  localparam seq_state_t S_FINISH = 3'd7;

  // configuration
  logic signed [TEMP_W-1:0] idle_limit;
  logic signed [TEMP_W-1:0] active_limit;
  logic signed [TEMP_W-1:0] throttle_limit;
  logic [HYST_W-1:0]        hysteresis;
  logic                     cfg_wr;

  // sequencer and state
  seq_state_t               state;
  logic                     primed;
  logic [WIN_AW-1:0]        write_slot;
  logic [WIN_AW-1:0]        fill_cnt;
  logic [1:0]               mode;
  logic signed [SUM_W-1:0]  win_sum;
  logic signed [TEMP_W-1:0] temp_q;
  logic signed [TEMP_W-1:0] f_q;
  logic [TEMP_W-1:0]        ramp_diff;
  logic [TEMP_W-1:0]        ramp_span;
  logic [DUTY_W-1:0]        duty_q;

  // window memory
  logic [TEMP_W-1:0]        win_mem [WINDOW_DEPTH];
  logic [TEMP_W-1:0]        rd_data;
  logic                     mem_we;
  logic [WIN_AW-1:0]        mem_waddr;

  // ramp divider
  logic [REM_W-1:0]         rem;
  logic [TEMP_W-1:0]        dbits;
  logic [REM_W-1:0]         divisor;
  logic [CNT_W-1:0]         step_cnt;
  logic                     op_ramp;
  logic [REM_W:0]           trial;
  logic                     trial_ge;

  // datapath helpers
  logic signed [SUM_W-1:0]  temp_ext;
  logic signed [SUM_W-1:0]  old_ext;
  logic signed [SUM_W-1:0]  fill_sum;
  logic signed [TEMP_W-1:0] f_new;
  logic signed [THR_W-1:0]  f_ext;
  logic signed [THR_W-1:0]  idle_ext;
  logic signed [THR_W-1:0]  active_ext;
  logic signed [THR_W-1:0]  throttle_ext;
  logic signed [THR_W-1:0]  idle_low;
  logic signed [THR_W-1:0]  active_low;
  logic signed [THR_W-1:0]  crit_low;
  logic [1:0]               mode_next;
  logic                     ramp_need;
  logic [PROD_W-1:0]        prod;
  logic [WIN_AW-1:0]        slot_inc;
  logic                     out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit     <= IDLE_LIMIT_RST;
      active_limit   <= ACTIVE_LIMIT_RST;
      throttle_limit <= THROTTLE_LIMIT_RST;
      hysteresis     <= HYSTERESIS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_IDLE_LIMIT:     idle_limit     <= pwdata[TEMP_W-1:0];
        REG_ACTIVE_LIMIT:   active_limit   <= pwdata[TEMP_W-1:0];
        REG_THROTTLE_LIMIT: throttle_limit <= pwdata[TEMP_W-1:0];
        REG_HYSTERESIS:     hysteresis     <= pwdata[HYST_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IDLE_LIMIT:     prdata = 32'(idle_limit);
      REG_ACTIVE_LIMIT:   prdata = 32'(active_limit);
      REG_THROTTLE_LIMIT: prdata = 32'(throttle_limit);
      REG_HYSTERESIS:     prdata = 32'(hysteresis);
    endcase
  end

  // window memory, one write and one registered read port
  assign mem_we    = (state == S_FILL) || (state == S_UPDATE);
  assign mem_waddr = (state == S_FILL) ? fill_cnt : write_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= temp_q;
    end
    rd_data <= win_mem[write_slot];
  end

  // datapath
  assign slot_inc = (write_slot == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : write_slot + 1'b1;
  assign temp_ext = SUM_W'(temp_q);
  assign old_ext  = SUM_W'($signed(rd_data));
  assign fill_sum = SUM_W'(temp_ext * $signed(SUM_W'(WINDOW_DEPTH)));

  // floored average: arithmetic shift by the window size
  assign f_new    = win_sum[SUM_W-1:WIN_AW];

  assign trial    = {rem, dbits[TEMP_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  assign f_ext        = THR_W'(f_q);
  assign idle_ext     = THR_W'(idle_limit);
  assign active_ext   = THR_W'(active_limit);
  assign throttle_ext = THR_W'(throttle_limit);
  assign idle_low     = idle_ext - $signed(THR_W'(hysteresis));
  assign active_low   = active_ext - $signed(THR_W'(hysteresis));
  assign crit_low     = throttle_ext
                      - $signed(THR_W'(THR_W'(hysteresis) * THR_W'(CRIT_HYST_FACTOR)));

  always_comb begin
    unique case (mode)
      MODE_IDLE: begin
        mode_next = (f_ext >= idle_ext) ? MODE_ACTIVE : MODE_IDLE;
      end
      MODE_ACTIVE: begin
        priority if (f_ext < idle_low) mode_next = MODE_IDLE;
        else if (f_ext >= active_ext)  mode_next = MODE_THROTTLING;
        else                           mode_next = MODE_ACTIVE;
      end
      MODE_THROTTLING: begin
        priority if (f_ext < active_low) mode_next = MODE_ACTIVE;
        else if (f_ext >= throttle_ext)  mode_next = MODE_CRITICAL;
        else                             mode_next = MODE_THROTTLING;
      end
      MODE_CRITICAL: begin
        mode_next = (f_ext < crit_low) ? MODE_THROTTLING : MODE_CRITICAL;
      end
    endcase
  end

  assign ramp_need = (mode_next == MODE_ACTIVE) && (f_ext > idle_ext) && (f_ext < active_ext);
  assign prod      = PROD_W'(ramp_diff) * PROD_W'(DUTY_SPAN);
  assign out_free  = !result_valid || !result_stall;

  assign sample_stall = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      primed       <= 1'b0;
      write_slot   <= '0;
      fill_cnt     <= '0;
      mode         <= MODE_IDLE;
      win_sum      <= '0;
      result_valid <= 1'b0;
      step_cnt     <= '0;
      op_ramp      <= 1'b0;
    end else begin
      if ((state == S_FINISH) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            temp_q   <= temperature;
            fill_cnt <= '0;
            state    <= primed ? S_UPDATE : S_FILL;
          end
        end
        S_FILL: begin
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt == WIN_AW'(WINDOW_DEPTH - 1)) begin
            win_sum    <= fill_sum;
            primed     <= 1'b1;
            write_slot <= slot_inc;
            state      <= S_AVG;
          end
        end
        S_UPDATE: begin
          win_sum    <= win_sum - old_ext + temp_ext;
          write_slot <= slot_inc;
          state      <= S_AVG;
        end
        S_AVG: begin
          f_q   <= f_new;
          state <= S_MODE;
        end
        S_DIV: begin
          rem      <= trial_ge ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
          dbits    <= {dbits[TEMP_W-2:0], trial_ge};
          step_cnt <= step_cnt - 1'b1;
          if (step_cnt == CNT_W'(1)) begin
            state <= S_FINISH;
          end
        end
        S_MODE: begin
          mode      <= mode_next;
          ramp_diff <= TEMP_W'(f_ext - idle_ext);
          ramp_span <= TEMP_W'(active_ext - idle_ext);
          op_ramp   <= 1'b0;
          state     <= ramp_need ? S_MUL : S_FINISH;
          unique case (mode_next)
            MODE_IDLE: duty_q <= '0;
            MODE_ACTIVE: begin
              duty_q <= (f_ext <= idle_ext) ? DUTY_W'(DUTY_LOW) : DUTY_W'(DUTY_HIGH);
            end
            MODE_THROTTLING: duty_q <= DUTY_W'(DUTY_HIGH);
            MODE_CRITICAL:   duty_q <= DUTY_W'(DUTY_HIGH);
          endcase
        end
        S_MUL: begin
          // quotient stays below 256, so the top bits start as the remainder
          rem      <= REM_W'(prod[PROD_W-1:DUTY_W]);
          dbits    <= {prod[DUTY_W-1:0], {(TEMP_W-DUTY_W){1'b0}}};
          divisor  <= ramp_span;
          step_cnt <= CNT_W'(RAMP_STEPS);
          op_ramp  <= 1'b1;
          state    <= S_DIV;
        end
        S_FINISH: begin
          if (out_free) begin
            filtered_temp <= f_q;
            thermal_mode  <= mode;
            fan_duty      <= op_ramp ? DUTY_W'(DUTY_LOW) + dbits[DUTY_W-1:0] : duty_q;
            unique case (mode)
              MODE_THROTTLING: power_state <= PWR_THROTTLED;
              MODE_CRITICAL:   power_state <= PWR_CRITICAL;
              default:         power_state <= PWR_NORMAL;
            endcase
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
